/* design/ubxfp_pkg.sv */
// Shared types and constants for the binary GNSS frame parser.
package ubxfp_pkg;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
    localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_MAX_LEN     = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BADSUM  = 3'd3,
        KIND_TOOLONG = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [15:0] payload_index;
        logic [7:0]  data_byte;
        logic        frame_end;
    } t_result;

endpackage

/* design/ubxfp_core.sv */
// Frame state machine, Fletcher-8 sums, configuration registers and result forming.
module ubxfp_core
    import ubxfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_write,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_res_valid,
    output t_result     o_res
);

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN1    = 4'd4,
        PH_LEN2    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CKA     = 4'd7,
        PH_CKB     = 4'd8
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_sum_a,        n_sum_a;
    logic [7:0]  r_sum_b,        n_sum_b;
    logic [7:0]  r_frame_class,  n_frame_class;
    logic [7:0]  r_frame_id,     n_frame_id;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic [15:0] r_max_len;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] full_len;
    logic [16:0] next_count;

    always_comb begin
        sum_a_add  = r_sum_a + i_rx_byte;
        sum_b_add  = r_sum_b + sum_a_add;
        full_len   = {i_rx_byte, r_frame_length[7:0]};
        next_count = {1'b0, r_byte_count} + 17'd1;

        n_phase        = r_phase;
        n_sum_a        = r_sum_a;
        n_sum_b        = r_sum_b;
        n_frame_class  = r_frame_class;
        n_frame_id     = r_frame_id;
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_HEADER;
        o_res.msg_class      = r_frame_class;
        o_res.msg_id         = r_frame_id;
        o_res.payload_length = r_frame_length;
        o_res.payload_index  = '0;
        o_res.data_byte      = '0;
        o_res.frame_end      = 1'b0;

        if (i_accept) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_rx_byte == r_sync_first) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    n_sum_a = '0;
                    n_sum_b = '0;
                    if (i_rx_byte == r_sync_second) begin
                        n_phase = PH_CLASS;
                    end else begin
                        n_phase        = PH_SYNC1;
                        n_frame_length = '0;
                        n_byte_count   = '0;
                    end
                end
                PH_CLASS: begin
                    n_sum_a       = sum_a_add;
                    n_sum_b       = sum_b_add;
                    n_frame_class = i_rx_byte;
                    n_phase       = PH_ID;
                end
                PH_ID: begin
                    n_sum_a    = sum_a_add;
                    n_sum_b    = sum_b_add;
                    n_frame_id = i_rx_byte;
                    n_phase    = PH_LEN1;
                end
                PH_LEN1: begin
                    n_sum_a        = sum_a_add;
                    n_sum_b        = sum_b_add;
                    n_frame_length = {8'd0, i_rx_byte};
                    n_phase        = PH_LEN2;
                end
                PH_LEN2: begin
                    o_res_valid          = 1'b1;
                    o_res.payload_length = full_len;
                    n_byte_count         = '0;
                    if (full_len > r_max_len) begin
                        o_res.kind      = KIND_TOOLONG;
                        o_res.frame_end = 1'b1;
                        n_phase         = PH_SYNC1;
                        n_sum_a         = '0;
                        n_sum_b         = '0;
                        n_frame_length  = '0;
                    end else begin
                        o_res.kind     = KIND_HEADER;
                        n_sum_a        = sum_a_add;
                        n_sum_b        = sum_b_add;
                        n_frame_length = full_len;
                        n_phase        = (full_len != 16'd0) ? PH_PAYLOAD : PH_CKA;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum_a             = sum_a_add;
                    n_sum_b             = sum_b_add;
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_DATA;
                    o_res.payload_index = r_byte_count;
                    o_res.data_byte     = i_rx_byte;
                    if (next_count >= {1'b0, r_frame_length}) begin
                        n_phase = PH_CKA;
                    end else begin
                        n_byte_count = next_count[15:0];
                    end
                end
                PH_CKA: begin
                    if (i_rx_byte != r_sum_a) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_BADSUM;
                        o_res.frame_end = 1'b1;
                        n_phase         = PH_SYNC1;
                        n_sum_a         = '0;
                        n_sum_b         = '0;
                        n_frame_length  = '0;
                        n_byte_count    = '0;
                    end else begin
                        n_phase = PH_CKB;
                    end
                end
                PH_CKB: begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = (i_rx_byte == r_sum_b) ? KIND_GOOD : KIND_BADSUM;
                    o_res.frame_end = 1'b1;
                    n_phase         = PH_SYNC1;
                    n_sum_a         = '0;
                    n_sum_b         = '0;
                    n_frame_length  = '0;
                    n_byte_count    = '0;
                end
                default: begin
                    n_phase        = PH_SYNC1;
                    n_sum_a        = '0;
                    n_sum_b        = '0;
                    n_frame_length = '0;
                    n_byte_count   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SYNC1;
            r_sum_a        <= '0;
            r_sum_b        <= '0;
            r_frame_class  <= '0;
            r_frame_id     <= '0;
            r_frame_length <= '0;
            r_byte_count   <= '0;
            r_sync_first   <= SYNC_FIRST_RST;
            r_sync_second  <= SYNC_SECOND_RST;
            r_max_len      <= MAX_LEN_RST;
        end else begin
            r_phase        <= n_phase;
            r_sum_a        <= n_sum_a;
            r_sum_b        <= n_sum_b;
            r_frame_class  <= n_frame_class;
            r_frame_id     <= n_frame_id;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            if (i_cfg_write) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                    CFG_MAX_LEN:     r_max_len     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* design/ubxfp_out_buf.sv */
// Result register with a skid stage between the parser and the output channel.
module ubxfp_out_buf
    import ubxfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_stall,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* design/ubx_frame_parser.sv */
// Top level of the binary GNSS frame parser with Fletcher-8 checking.
//
// Input channel: one received byte per beat on i_rx_byte, i_valid / o_stall.
// Output channel: one result per beat on the o_ fields, o_valid / i_stall.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 first sync byte, 1 second sync byte, 2 longest payload. Other
// indexes are ignored. Writes are always ready and take effect next cycle.
// A byte is taken in each cycle with i_valid high and o_stall low; the frame state advances in that cycle.
// A byte that gives a result has it registered in the result register, or in
// the skid stage while the receiver stalls. Sync, class, id, low length,
// checksum A (when correct) and hunting bytes give none.
// Throughput is one byte per cycle while o_stall is low.
// A skid stage behind the result register holds one more result while the
// receiver stalls; o_stall rises only once that stage is occupied.
// Reset returns the parser to hunting for the first sync byte, clears sums,
// frame fields and counters, empties the output stages and restores the
// configuration defaults 0xB5, 0x62 and 1024.
module ubx_frame_parser
    import ubxfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_msg_class,
    output logic [7:0]  o_msg_id,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_data_byte,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out;

    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    ubxfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ubxfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (out),
        .i_stall (i_stall)
    );

    assign o_kind           = out.kind;
    assign o_msg_class      = out.msg_class;
    assign o_msg_id         = out.msg_id;
    assign o_payload_length = out.payload_length;
    assign o_payload_index  = out.payload_index;
    assign o_data_byte      = out.data_byte;
    assign o_frame_end      = out.frame_end;

endmodule

/* design/ubxfp_checker.sv */
// Port-level checks on the frame parser, bound to its top level.
module ubxfp_checker
    import ubxfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [2:0]  o_kind,
    input  logic [15:0] o_payload_length,
    input  logic [15:0] o_payload_index,
    input  logic [7:0]  o_data_byte,
    input  logic        o_frame_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_payload_index))
        else $error("stalled result beat changed");

    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_end == (o_kind == KIND_GOOD || o_kind == KIND_BADSUM
            || o_kind == KIND_TOOLONG))
        else $error("frame end flag disagrees with kind");

    a_non_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_data_byte == 8'd0 && o_payload_index == 16'd0)
        else $error("non-payload result carries data");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA |-> o_payload_index < o_payload_length)
        else $error("payload index beyond declared length");

endmodule

bind ubx_frame_parser ubxfp_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_payload_length (o_payload_length),
    .o_payload_index  (o_payload_index),
    .o_data_byte      (o_data_byte),
    .o_frame_end      (o_frame_end)
);
